[rtl/core/queued_step_pulse_generator_defines.svh]
// assertion macros for the queued step pulse generator
`ifndef QUEUED_STEP_PULSE_GENERATOR_DEFINES_SVH
`define QUEUED_STEP_PULSE_GENERATOR_DEFINES_SVH

// same-cycle implication, checked on clk_i with rst_ni low as disable
`define QSPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QSPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/qspg_pkg.sv]
// types, constants and helpers shared by the step pulse generator
`timescale 1ns / 1ps
package qspg_pkg;

  localparam int unsigned QSPG_QUEUE_LEN = 16;
  localparam logic [15:0] QSPG_START_DELAY_RST = 16'd10;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_PUSH  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;
  localparam logic [1:0] FUNC_STOP  = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_PUSH,
    OP_START,
    OP_STOP
  } qspg_op_e;

  typedef enum logic [1:0] {
    ST_EXEC,
    ST_READ,
    ST_LOAD
  } qspg_state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] period_ticks;
    logic [7:0]  step_count;
    logic        dir_flip;
  } qspg_in_t;

  typedef struct packed {
    logic       step_pulse;
    logic       dir_level;
    logic       running;
    logic [4:0] queue_count;
    logic       accepted;
  } qspg_out_t;

  typedef struct packed {
    logic [15:0] period;
    logic [7:0]  steps;
    logic        toggle;
  } qspg_cmd_t;

  typedef struct packed {
    qspg_op_e  op;
    qspg_cmd_t cmd;
  } qspg_op_t;

  // a period of zero stands for a full 16-bit wrap
  function automatic logic [16:0] qspg_as_ticks(input logic [15:0] v);
    return (v == 16'd0) ? 17'h10000 : {1'b0, v};
  endfunction

endpackage

[rtl/core/queued_step_pulse_generator.sv]
// top level of the queued step pulse generator
`timescale 1ns / 1ps
// Step pulse generator for one axis, fed from a ring of QUEUE_LEN commands.
// Items (tick, push, start, stop) enter on start_i while busy_o is low and go
// into a two-entry op queue; busy_o rises only when that queue is full. Each
// item gives exactly one result, shown on res_o for one cycle with res_valid_o
// high; the receiver cannot stall it. Items sustain one per cycle while the
// executor stays in its execute state, with the result registered and shown in
// the cycle after execution. A start or compare event whose command entry is
// not yet cached passes through a load state and then a retry, and one that
// moves on to the next entry passes through a read state and a load state;
// these come from the registered read port of the command ram. The start delay
// register resets to 10 and is written on cfg_valid_i, which is always ready.
module queued_step_pulse_generator #(
  parameter int unsigned QUEUE_LEN = qspg_pkg::QSPG_QUEUE_LEN
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  qspg_pkg::qspg_in_t  in_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output qspg_pkg::qspg_out_t res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);
  import qspg_pkg::*;

`include "queued_step_pulse_generator_defines.svh"

  logic [15:0] start_delay_q;
  logic        op_valid;
  logic        op_pop;
  qspg_op_t    op;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delay_q <= QSPG_START_DELAY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      start_delay_q <= cfg_data_i;
    end
  end

  qspg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .in_i       (in_i),
    .busy_o     (busy_o),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  qspg_back #(
    .QUEUE_LEN (QUEUE_LEN)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (op_valid),
    .op_i          (op),
    .op_pop_o      (op_pop),
    .start_delay_i (start_delay_q),
    .res_valid_o   (res_valid_o),
    .res_o         (res_o)
  );

  `QSPG_ASSERT_NOW(a_pulse_running, res_valid_o && res_o.step_pulse, res_o.running,
                   "step pulse while generator idle")
  `QSPG_ASSERT_NOW(a_push_no_pulse, res_valid_o && res_o.accepted, !res_o.step_pulse,
                   "pulse on a push transfer")
  `QSPG_ASSERT_NEXT(a_op_queued, start_i && !busy_o, op_valid,
                    "accepted item missing from op queue")

endmodule

[rtl/core/qspg_ram.sv]
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module qspg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/qspg_front.sv]
// front end: takes items, decodes the function code, holds a two-entry op queue
`timescale 1ns / 1ps
module qspg_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  qspg_pkg::qspg_in_t  in_i,
  output logic                busy_o,
  output logic                op_valid_o,
  output qspg_pkg::qspg_op_t  op_o,
  input  logic                op_pop_i
);
  import qspg_pkg::*;

  qspg_op_t   slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  qspg_op_t   dec;

  always_comb begin
    unique case (in_i.func)
      FUNC_TICK:  dec.op = OP_TICK;
      FUNC_PUSH:  dec.op = OP_PUSH;
      FUNC_START: dec.op = OP_START;
      FUNC_STOP:  dec.op = OP_STOP;
      default:    dec.op = OP_TICK;
    endcase
    dec.cmd.period = in_i.period_ticks;
    dec.cmd.steps  = in_i.step_count;
    dec.cmd.toggle = in_i.dir_flip;
  end

  assign busy_o     = (cnt_q == 2'd2);
  assign push       = start_i && !busy_o;
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = slot_q[rd_q];

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = op_pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, op_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= dec;
    end
  end

endmodule

[rtl/core/qspg_back.sv]
// back end: command ring, countdown timer and compare-event sequencer
`timescale 1ns / 1ps
module qspg_back #(
  parameter int unsigned QUEUE_LEN = qspg_pkg::QSPG_QUEUE_LEN
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_valid_i,
  input  qspg_pkg::qspg_op_t  op_i,
  output logic                op_pop_o,
  input  logic [15:0]         start_delay_i,
  output logic                res_valid_o,
  output qspg_pkg::qspg_out_t res_o
);
  import qspg_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_LEN);
  localparam int unsigned PTR_W = $clog2(2 * QUEUE_LEN);
  localparam logic [PTR_W-1:0] PtrLast = PTR_W'(2 * QUEUE_LEN - 1);
  localparam logic [PTR_W-1:0] PtrLen  = PTR_W'(QUEUE_LEN);
  localparam logic [PTR_W:0]   PtrSpan = (PTR_W + 1)'(2 * QUEUE_LEN);

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PtrLast) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] to_idx(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p >= PtrLen) ? p - PtrLen : p;
    return r[IDX_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] fill(input logic [PTR_W-1:0] w,
                                            input logic [PTR_W-1:0] r);
    logic [PTR_W:0] s;
    s = {1'b0, w} + ((w < r) ? PtrSpan : '0) - {1'b0, r};
    return s[PTR_W-1:0];
  endfunction

  qspg_state_e      state_q, state_d;
  logic [PTR_W-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [16:0]      tr_q, tr_d;
  logic             armed_q, armed_d;
  logic             drain_q, drain_d;
  logic             active_q, active_d;
  logic             dir_q, dir_d;
  logic             loaded_q, loaded_d;
  logic             apply_q, apply_d;
  logic             ppulse_q, ppulse_d;
  qspg_cmd_t        head_q, head_d;
  logic             res_valid_q, res_valid_d;
  qspg_out_t        res_q, res_d;
  logic             emit, res_pulse, res_acc, we;
  logic             empty, full;
  logic [PTR_W-1:0] rp_nx, cnt_d;
  qspg_cmd_t        rdata;

  qspg_ram #(
    .WIDTH ($bits(qspg_cmd_t)),
    .DEPTH (QUEUE_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (to_idx(wp_q)),
    .wdata_i (op_i.cmd),
    .raddr_i (to_idx(rp_q)),
    .rdata_o (rdata)
  );

  assign empty = (rp_q == wp_q);
  assign full  = (fill(wp_q, rp_q) == PtrLen);
  assign rp_nx = ptr_next(rp_q);

  always_comb begin
    state_d   = state_q;
    rp_d      = rp_q;
    wp_d      = wp_q;
    tr_d      = tr_q;
    armed_d   = armed_q;
    drain_d   = drain_q;
    active_d  = active_q;
    dir_d     = dir_q;
    loaded_d  = loaded_q;
    apply_d   = apply_q;
    ppulse_d  = ppulse_q;
    head_d    = head_q;
    emit      = 1'b0;
    res_pulse = 1'b0;
    res_acc   = 1'b0;
    we        = 1'b0;
    unique case (state_q)
      ST_EXEC: begin
        if (op_valid_i) begin
          unique case (op_i.op)
            OP_TICK: begin
              if (!active_q) begin
                emit = 1'b1;
              end else if (tr_q > 17'd1) begin
                tr_d = tr_q - 17'd1;
                emit = 1'b1;
              end else if (empty) begin
                res_pulse = armed_q;
                active_d  = 1'b0;
                drain_d   = 1'b0;
                armed_d   = 1'b0;
                tr_d      = '0;
                emit      = 1'b1;
              end else if (!loaded_q) begin
                state_d = ST_LOAD;
              end else begin
                res_pulse = armed_q;
                armed_d   = 1'b0;
                if (drain_q) begin
                  drain_d = 1'b0;
                  tr_d    = (head_q.steps != 8'd0) ? qspg_as_ticks(start_delay_i)
                                                   : qspg_as_ticks(head_q.period);
                  dir_d   = dir_q ^ head_q.toggle;
                  armed_d = (head_q.steps != 8'd0);
                  emit    = 1'b1;
                end else if (head_q.steps > 8'd1) begin
                  head_d.steps = head_q.steps - 8'd1;
                  armed_d      = 1'b1;
                  tr_d         = qspg_as_ticks(head_q.period);
                  emit         = 1'b1;
                end else begin
                  rp_d     = rp_nx;
                  tr_d     = qspg_as_ticks(head_q.period);
                  loaded_d = 1'b0;
                  if (rp_nx == wp_q) begin
                    drain_d = 1'b1;
                    emit    = 1'b1;
                  end else begin
                    ppulse_d = armed_q;
                    apply_d  = 1'b1;
                    state_d  = ST_READ;
                  end
                end
              end
            end
            OP_PUSH: begin
              if (!full) begin
                we      = 1'b1;
                wp_d    = ptr_next(wp_q);
                res_acc = 1'b1;
              end
              emit = 1'b1;
            end
            OP_START: begin
              if (!active_q && !empty) begin
                if (!loaded_q) begin
                  state_d = ST_LOAD;
                end else begin
                  active_d = 1'b1;
                  drain_d  = 1'b0;
                  dir_d    = dir_q ^ head_q.toggle;
                  armed_d  = (head_q.steps != 8'd0);
                  tr_d     = qspg_as_ticks(start_delay_i);
                  emit     = 1'b1;
                end
              end else begin
                emit = 1'b1;
              end
            end
            OP_STOP: begin
              active_d = 1'b0;
              armed_d  = 1'b0;
              drain_d  = 1'b0;
              tr_d     = '0;
              rp_d     = wp_q;
              loaded_d = 1'b0;
              emit     = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        head_d   = rdata;
        loaded_d = 1'b1;
        state_d  = ST_EXEC;
        if (apply_q) begin
          apply_d   = 1'b0;
          dir_d     = dir_q ^ rdata.toggle;
          armed_d   = (rdata.steps != 8'd0);
          res_pulse = ppulse_q;
          emit      = 1'b1;
        end
      end
      default: state_d = ST_EXEC;
    endcase

    cnt_d             = fill(wp_d, rp_d);
    res_valid_d       = emit;
    res_d.step_pulse  = res_pulse;
    res_d.dir_level   = dir_d;
    res_d.running     = active_d;
    res_d.queue_count = 5'(cnt_d);
    res_d.accepted    = res_acc;
  end

  assign op_pop_o    = emit;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_EXEC;
      rp_q        <= '0;
      wp_q        <= '0;
      tr_q        <= '0;
      armed_q     <= 1'b0;
      drain_q     <= 1'b0;
      active_q    <= 1'b0;
      dir_q       <= 1'b0;
      loaded_q    <= 1'b0;
      apply_q     <= 1'b0;
      ppulse_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      tr_q        <= tr_d;
      armed_q     <= armed_d;
      drain_q     <= drain_d;
      active_q    <= active_d;
      dir_q       <= dir_d;
      loaded_q    <= loaded_d;
      apply_q     <= apply_d;
      ppulse_q    <= ppulse_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    res_q  <= res_d;
  end

endmodule

[dv/tb_queued_step_pulse_generator.sv]
// self-checking testbench for the queued step pulse generator
`timescale 1ns / 1ps
module tb_queued_step_pulse_generator;
  import qspg_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned QUIET_CYCLES = 6;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned SEG_ITEMS    = 90;
  localparam int unsigned NUM_SEGS     = 5;

  typedef enum logic [1:0] {
    ACT_ITEM,
    ACT_CFG,
    ACT_DRAIN
  } act_kind_e;

  typedef struct {
    act_kind_e   kind;
    qspg_in_t    item;
    logic [15:0] cfg_val;
  } plan_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start_i     = 1'b0;
  qspg_in_t    in_i        = '0;
  logic        busy_o;
  logic        res_valid_o;
  qspg_out_t   res_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i  = '0;

  plan_t       plan_q[$];
  qspg_out_t   step_results_q[$];
  int unsigned plan_items;
  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned gap_cnt;
  int unsigned quiet_cnt;
  logic        no_gaps = 1'b0;
  logic [15:0] gen_delay;

  // predicted state of the generator
  qspg_cmd_t   cmd_mem [QSPG_QUEUE_LEN];
  logic [4:0]  p_rd;
  logic [4:0]  p_wr;
  logic [16:0] p_ticks;
  logic        p_armed;
  logic        p_draining;
  logic        p_active;
  logic        p_dir;
  logic [15:0] p_delay;

  queued_step_pulse_generator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .in_i        (in_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // zero stands for a full 16-bit wrap
  function automatic logic [16:0] span_of(input logic [15:0] v);
    return {(v == 16'd0), v};
  endfunction

  function automatic void arm_entry(input logic [3:0] slot);
    if (cmd_mem[slot].toggle) p_dir = ~p_dir;
    p_armed = (cmd_mem[slot].steps != 8'd0);
  endfunction

  function automatic qspg_out_t predict_step_result(input qspg_in_t it);
    qspg_out_t   r;
    logic [3:0]  slot;
    logic [15:0] per;
    logic [4:0]  fill;
    r    = '0;
    fill = p_wr - p_rd;
    case (it.func)
      FUNC_TICK: begin
        if (p_active && p_ticks > 17'd1) begin
          p_ticks = p_ticks - 17'd1;
        end else if (p_active) begin
          r.step_pulse = p_armed;
          if (p_rd == p_wr) begin
            p_active   = 1'b0;
            p_draining = 1'b0;
            p_armed    = 1'b0;
            p_ticks    = '0;
          end else begin
            slot    = p_rd[3:0];
            per     = cmd_mem[slot].period;
            p_armed = 1'b0;
            if (p_draining) begin
              // late command after the final wait
              p_draining = 1'b0;
              p_ticks    = (cmd_mem[slot].steps != 8'd0) ? span_of(p_delay) : span_of(per);
              arm_entry(slot);
            end else begin
              if (cmd_mem[slot].steps > 8'd1) begin
                cmd_mem[slot].steps = cmd_mem[slot].steps - 8'd1;
                p_armed             = 1'b1;
              end else begin
                p_rd = p_rd + 5'd1;
                if (p_rd == p_wr) p_draining = 1'b1;
                else arm_entry(p_rd[3:0]);
              end
              p_ticks = span_of(per);
            end
          end
        end
      end
      FUNC_PUSH: begin
        if (fill < 5'(QSPG_QUEUE_LEN)) begin
          cmd_mem[p_wr[3:0]] = {it.period_ticks, it.step_count, it.dir_flip};
          p_wr               = p_wr + 5'd1;
          r.accepted         = 1'b1;
        end
      end
      FUNC_START: begin
        if (!p_active && p_rd != p_wr) begin
          p_active   = 1'b1;
          p_draining = 1'b0;
          arm_entry(p_rd[3:0]);
          p_ticks    = span_of(p_delay);
        end
      end
      FUNC_STOP: begin
        p_active   = 1'b0;
        p_armed    = 1'b0;
        p_draining = 1'b0;
        p_ticks    = '0;
        p_rd       = p_wr;
      end
    endcase
    r.dir_level   = p_dir;
    r.running     = p_active;
    r.queue_count = p_wr - p_rd;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [4:0] got,
                                 input logic [4:0] want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
    err_cnt++;
  endtask

  task automatic add_item(input logic [1:0] f, input logic [15:0] per,
                          input logic [7:0] stp, input logic tog);
    plan_t p;
    p.kind    = ACT_ITEM;
    p.item    = '{func: f, period_ticks: per, step_count: stp, dir_flip: tog};
    p.cfg_val = '0;
    plan_q.push_back(p);
    plan_items++;
  endtask

  task automatic add_op(input logic [1:0] f);
    add_item(f, 16'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic add_ticks(input int n);
    for (int i = 0; i < n; i++) add_op(FUNC_TICK);
  endtask

  task automatic add_setting(input logic [15:0] d);
    plan_t p;
    p.kind    = ACT_CFG;
    p.item    = '0;
    p.cfg_val = d;
    plan_q.push_back(p);
    gen_delay = d;
  endtask

  task automatic add_pause();
    plan_t p;
    p.kind    = ACT_DRAIN;
    p.item    = '0;
    p.cfg_val = '0;
    plan_q.push_back(p);
  endtask

  // commands, a start and ticks to play short runs out
  task automatic add_run();
    int          n_cmds;
    int          est;
    int          t_per;
    int          last_per;
    int          n_ticks;
    int          mid;
    logic        stop_after;
    logic [15:0] per;
    logic [7:0]  stp;
    n_cmds   = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 17) : $urandom_range(1, 4);
    est      = (gen_delay == 16'd0) ? 65536 : int'(gen_delay);
    last_per = 1;
    for (int i = 0; i < n_cmds; i++) begin
      per = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
      stp = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
      add_item(FUNC_PUSH, per, stp, 1'($urandom));
      t_per    = (per == 16'd0) ? 65536 : int'(per);
      est      = est + t_per * ((stp == 8'd0) ? 1 : int'(stp));
      last_per = t_per;
    end
    est = est + last_per + 2;
    add_op(FUNC_START);
    if ($urandom_range(0, 3) == 0) add_op(FUNC_START);
    if (est > 80) begin
      n_ticks    = $urandom_range(3, 60);
      stop_after = 1'b1;
    end else begin
      n_ticks    = est + $urandom_range(0, 3);
      stop_after = ($urandom_range(0, 5) == 0);
    end
    mid = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_ticks) : -1;
    for (int i = 0; i < n_ticks; i++) begin
      if (i == mid) begin
        add_item(FUNC_PUSH, 16'($urandom_range(1, 4)), 8'($urandom_range(0, 3)),
                 1'($urandom));
      end
      add_op(FUNC_TICK);
    end
    if (stop_after) add_op(FUNC_STOP);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic hold_start;
    logic hold_cfg;
    if (!rst_ni) begin
      start_i     <= 1'b0;
      in_i        <= '0;
      cfg_valid_i <= 1'b0;
      cfg_data_i  <= '0;
      gap_cnt     = 0;
      quiet_cnt   = 0;
    end else begin
      hold_start = start_i;
      hold_cfg   = cfg_valid_i;
      if (start_i && !busy_o) begin
        step_results_q.push_back(predict_step_result(in_i));
        void'(plan_q.pop_front());
        hold_start = 1'b0;
        if ($urandom_range(0, 31) == 0) no_gaps = ~no_gaps;
        gap_cnt = no_gaps ? 0 : $urandom_range(0, 3);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        p_delay = cfg_data_i;
        void'(plan_q.pop_front());
        hold_cfg = 1'b0;
      end
      if (!hold_start && !hold_cfg && plan_q.size() != 0) begin
        if (plan_q[0].kind == ACT_ITEM) begin
          if (gap_cnt == 0) begin
            hold_start = 1'b1;
            in_i       <= plan_q[0].item;
          end else begin
            gap_cnt--;
          end
        end else if (step_results_q.size() != 0) begin
          quiet_cnt = 0;
        end else if (quiet_cnt < QUIET_CYCLES) begin
          quiet_cnt++;
        end else begin
          // block is idle here
          quiet_cnt = 0;
          if (plan_q[0].kind == ACT_CFG) begin
            hold_cfg   = 1'b1;
            cfg_data_i <= plan_q[0].cfg_val;
          end else begin
            void'(plan_q.pop_front());
          end
        end
      end
      start_i     <= hold_start;
      cfg_valid_i <= hold_cfg;
    end
  end

  always @(posedge clk_i) begin : monitor
    qspg_out_t want;
    if (rst_ni && res_valid_o) begin
      if (step_results_q.size() == 0) begin
        report_mismatch("result with nothing pending", 5'd1, 5'd0);
      end else begin
        want = step_results_q.pop_front();
        if (res_o.step_pulse !== want.step_pulse)
          report_mismatch("step_pulse", 5'(res_o.step_pulse), 5'(want.step_pulse));
        if (res_o.dir_level !== want.dir_level)
          report_mismatch("dir_level", 5'(res_o.dir_level), 5'(want.dir_level));
        if (res_o.running !== want.running)
          report_mismatch("running", 5'(res_o.running), 5'(want.running));
        if (res_o.queue_count !== want.queue_count)
          report_mismatch("queue_count", res_o.queue_count, want.queue_count);
        if (res_o.accepted !== want.accepted)
          report_mismatch("accepted", 5'(res_o.accepted), 5'(want.accepted));
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int          pick;
    logic [15:0] seg_delay [NUM_SEGS];
    err_cnt    = 0;
    plan_items = 0;
    for (int i = 0; i < QSPG_QUEUE_LEN; i++) cmd_mem[i] = '0;
    p_rd       = '0;
    p_wr       = '0;
    p_ticks    = '0;
    p_armed    = 1'b0;
    p_draining = 1'b0;
    p_active   = 1'b0;
    p_dir      = 1'b0;
    p_delay    = QSPG_START_DELAY_RST;
    gen_delay  = QSPG_START_DELAY_RST;

    // idle cases and extremes with the reset start delay
    add_op(FUNC_TICK);
    add_op(FUNC_START);
    add_op(FUNC_STOP);
    add_item(FUNC_PUSH, 16'hffff, 8'hff, 1'b1);
    add_item(FUNC_PUSH, 16'h0000, 8'h00, 1'b0);
    add_item(FUNC_PUSH, 16'h0001, 8'h01, 1'b1);
    add_op(FUNC_START);
    add_op(FUNC_START);
    add_ticks(11);
    add_op(FUNC_STOP);
    add_op(FUNC_TICK);

    seg_delay[0] = 16'd1;
    seg_delay[1] = 16'($urandom_range(2, 6));
    seg_delay[2] = 16'hffff;
    seg_delay[3] = 16'd3;
    seg_delay[4] = 16'($urandom_range(1, 4));
    plan_items   = 0;
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      add_setting(seg_delay[seg]);
      while (plan_items < (seg + 1) * SEG_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
          add_run();
        end else if (pick <= 7) begin
          repeat ($urandom_range(1, 6)) add_op(2'($urandom));
        end else if (pick == 8) begin
          add_pause();
        end else begin
          // overfill the queue
          repeat (17) begin
            add_item(FUNC_PUSH, 16'($urandom_range(1, 4)), 8'($urandom_range(0, 4)),
                     1'($urandom));
          end
          add_op(FUNC_STOP);
        end
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (plan_q.size() != 0 || step_results_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
